>>> src/fdr_pkg.sv
// Shared types and constants for the changed-cell run detector.
package fdr_pkg;

  localparam int COLOR_W     = 8;
  localparam int GLYPH_W     = 21;
  localparam int COL_OUT_W   = 7;
  localparam int ROW_OUT_W   = 6;
  localparam int CFG_DATA_W  = 8;
  localparam int FCOLS_W     = 8;
  localparam int FROWS_W     = 7;

  localparam logic [FCOLS_W-1:0] FRAME_COLUMNS_RESET = 8'd40;
  localparam logic [FROWS_W-1:0] FRAME_ROWS_RESET    = 7'd20;

  localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 21'h00_0020;
  localparam logic [GLYPH_W-1:0] HALF_BLOCK  = 21'h00_2584;
  localparam logic [6*COLOR_W-1:0] BLACK_COLORS = 48'h0;

  typedef enum logic [0:0] {
    CFG_FRAME_COLUMNS = 1'b0,
    CFG_FRAME_ROWS    = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg_red;
    logic [COLOR_W-1:0] fg_green;
    logic [COLOR_W-1:0] fg_blue;
    logic [COLOR_W-1:0] bg_red;
    logic [COLOR_W-1:0] bg_green;
    logic [COLOR_W-1:0] bg_blue;
    logic [GLYPH_W-1:0] glyph;
  } in_item_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] cell_column;
    logic [ROW_OUT_W-1:0] cell_row;
    logic                 run_start;
    logic [COLOR_W-1:0]   out_fg_red;
    logic [COLOR_W-1:0]   out_fg_green;
    logic [COLOR_W-1:0]   out_fg_blue;
    logic [COLOR_W-1:0]   out_bg_red;
    logic [COLOR_W-1:0]   out_bg_green;
    logic [COLOR_W-1:0]   out_bg_blue;
    logic [GLYPH_W-1:0]   shown_glyph;
  } out_item_t;

  typedef struct packed {
    logic [6*COLOR_W-1:0] colors;
    logic [GLYPH_W-1:0]   glyph;
  } cell_t;

  localparam cell_t BLANK_CELL = '{colors: BLACK_COLORS, glyph: BLANK_GLYPH};

endpackage

>>> src/fdr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  clk,
  we,
  waddr,
  wdata,
  re,
  raddr,
  rdata
);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic              clk;
  input  logic              we;
  input  logic [ADDR_W-1:0] waddr;
  input  logic [WIDTH-1:0]  wdata;
  input  logic              re;
  input  logic [ADDR_W-1:0] raddr;
  output logic [WIDTH-1:0]  rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/fdr_pos.sv
// Raster position counters and store address generation.
module fdr_pos #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int ADDR_W = (MAX_COLUMNS * MAX_ROWS > 1) ? $clog2(MAX_COLUMNS * MAX_ROWS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [fdr_pkg::FCOLS_W-1:0] frame_columns,
  input  logic [fdr_pkg::FROWS_W-1:0] frame_rows,
  output logic [COL_W-1:0]            col,
  output logic [ROW_W-1:0]            row,
  output logic [ADDR_W-1:0]           addr,
  output logic                        row_end
);
  import fdr_pkg::*;

  localparam int CCMP_W = ($clog2(MAX_COLUMNS + 1) > FCOLS_W) ? $clog2(MAX_COLUMNS + 1) : FCOLS_W;
  localparam int RCMP_W = ($clog2(MAX_ROWS + 1) > FROWS_W) ? $clog2(MAX_ROWS + 1) : FROWS_W;

  logic [ADDR_W-1:0] row_base;
  logic [CCMP_W-1:0] col_inc;
  logic [RCMP_W-1:0] row_inc;
  logic              frame_end;

  assign col_inc   = CCMP_W'(col) + CCMP_W'(1);
  assign row_inc   = RCMP_W'(row) + RCMP_W'(1);
  assign row_end   = (col_inc >= CCMP_W'(frame_columns)) || (col_inc >= CCMP_W'(MAX_COLUMNS));
  assign frame_end = (row_inc >= RCMP_W'(frame_rows)) || (row_inc >= RCMP_W'(MAX_ROWS));
  assign addr      = row_base + ADDR_W'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (advance) begin
      if (row_end) begin
        col <= '0;
        if (frame_end) begin
          row      <= '0;
          row_base <= '0;
        end else begin
          row      <= row + ROW_W'(1);
          row_base <= row_base + ADDR_W'(MAX_COLUMNS);
        end
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

>>> src/frame_diff_changed_pixel_runs_unit.sv
// Top level of the changed-cell run detector: frame store, compare stage and output register.
//
//   Channel   Signals                          Direction  Contents
//   in        in_valid, in_ready, in_data      input      one character cell, raster order
//   out       out_valid, out_ready, out_data   output     one changed cell with position
//   cfg       cfg_write, cfg_index, cfg_data   input      frame width and height in use
//
// The frame store is read at the edge that accepts a cell, and the compare and write-back
// take the next cycle, and a changed cell moves on into the output register when the
// compare stage advances; a new cell is accepted every cycle while the output does not stall.
// After reset the frame store is swept to black spaces, one entry per cycle, and no cell
// is accepted during the sweep.
// A stalled output holds the compare stage while it holds a changed cell, which holds the input.
module frame_diff_changed_pixel_runs_unit #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fdr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fdr_pkg::out_item_t             out_data,
  input  logic                           cfg_write,
  input  fdr_pkg::cfg_index_t            cfg_index,
  input  logic [fdr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fdr_pkg::*;

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [FCOLS_W-1:0] frame_columns;
  logic [FROWS_W-1:0] frame_rows;

  logic               clr_active;
  logic [ADDR_W-1:0]  clr_addr;

  logic               accept;
  logic [COL_W-1:0]   pos_col;
  logic [ROW_W-1:0]   pos_row;
  logic [ADDR_W-1:0]  pos_addr;
  logic               pos_row_end;

  logic               s1_valid;
  in_item_t           s1_item;
  logic [ADDR_W-1:0]  s1_addr;
  logic [COL_W-1:0]   s1_col;
  logic [ROW_W-1:0]   s1_row;
  logic               s1_row_end;
  logic               s1_fwd;
  cell_t              s1_fwd_cell;
  logic               in_run;

  logic [$bits(cell_t)-1:0] ram_rdata;
  cell_t              prev_cell;
  cell_t              new_cell;
  logic               changed;
  logic               s1_advance;
  logic               cell_write;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  cell_t              ram_wdata;
  out_item_t          result;

  function automatic logic [6*COLOR_W-1:0] in_color(input in_item_t item);
    return {item.fg_red, item.fg_green, item.fg_blue,
            item.bg_red, item.bg_green, item.bg_blue};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_columns <= FRAME_COLUMNS_RESET;
      frame_rows    <= FRAME_ROWS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_COLUMNS: frame_columns <= cfg_data[FCOLS_W-1:0];
        CFG_FRAME_ROWS:    frame_rows    <= cfg_data[FROWS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  fdr_pos #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_pos (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .frame_columns(frame_columns),
    .frame_rows   (frame_rows),
    .col          (pos_col),
    .row          (pos_row),
    .addr         (pos_addr),
    .row_end      (pos_row_end)
  );

  assign new_cell   = '{colors: in_color(s1_item), glyph: s1_item.glyph};
  assign prev_cell  = s1_fwd ? s1_fwd_cell : cell_t'(ram_rdata);
  assign changed    = (prev_cell != new_cell);
  assign s1_advance = s1_valid && (!changed || !out_valid || out_ready);
  assign cell_write = s1_advance && changed;
  assign in_ready   = !clr_active && (!s1_valid || s1_advance);
  assign accept     = in_valid && in_ready;

  assign ram_we    = clr_active || cell_write;
  assign ram_waddr = clr_active ? clr_addr : s1_addr;
  assign ram_wdata = clr_active ? BLANK_CELL : new_cell;

  fdr_ram #(
    .WIDTH($bits(cell_t)),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(pos_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      in_run   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        in_run <= changed && !s1_row_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item     <= in_data;
      s1_addr     <= pos_addr;
      s1_col      <= pos_col;
      s1_row      <= pos_row;
      s1_row_end  <= pos_row_end;
      s1_fwd      <= cell_write && (s1_addr == pos_addr);
      s1_fwd_cell <= new_cell;
    end
  end

  always_comb begin
    result.cell_column  = COL_OUT_W'(s1_col);
    result.cell_row     = ROW_OUT_W'(s1_row);
    result.run_start    = !in_run;
    result.out_fg_red   = s1_item.fg_red;
    result.out_fg_green = s1_item.fg_green;
    result.out_fg_blue  = s1_item.fg_blue;
    result.out_bg_red   = s1_item.bg_red;
    result.out_bg_green = s1_item.bg_green;
    result.out_bg_blue  = s1_item.bg_blue;
    result.shown_glyph  = (s1_item.glyph == BLANK_GLYPH) ? HALF_BLOCK : s1_item.glyph;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cell_write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_write) begin
      out_data <= result;
    end
  end

endmodule

>>> tb/sv/tb_frame_diff_changed_pixel_runs_unit.sv
// Self-checking testbench for the changed-cell run detector: directed cells, random frames.
`timescale 1ns / 100ps

module tb_frame_diff_changed_pixel_runs_unit;
  import fdr_pkg::*;

  localparam int FRAME_MAX_COLUMNS = 128;
  localparam int FRAME_MAX_ROWS = 64;
  localparam int STORE_CELLS = FRAME_MAX_COLUMNS * FRAME_MAX_ROWS;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT = 50000;
  localparam int PRINT_CAP = 100;

  class changed_cell_scoreboard;
    logic [6*COLOR_W-1:0] frame_colors [STORE_CELLS];
    logic [GLYPH_W-1:0] frame_glyphs [STORE_CELLS];
    int unsigned cols_reg;
    int unsigned rows_reg;
    int unsigned cur_col;
    int unsigned cur_row;
    bit prev_changed;
    out_item_t pending_cells[$];
    int unsigned errors;

    function new();
      foreach (frame_colors[i]) begin
        frame_colors[i] = BLACK_COLORS;
        frame_glyphs[i] = BLANK_GLYPH;
      end
      cols_reg = 32'(FRAME_COLUMNS_RESET);
      rows_reg = 32'(FRAME_ROWS_RESET);
      cur_col = 0;
      cur_row = 0;
      prev_changed = 1'b0;
      errors = 0;
    endfunction

    function void set_size(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_FRAME_COLUMNS) begin
        cols_reg = 32'(value);
      end else begin
        rows_reg = 32'(value[FROWS_W-1:0]);
      end
    endfunction

    function int unsigned size_in_use(int unsigned value, int unsigned limit);
      if (value == 0) return 1;
      return (value > limit) ? limit : value;
    endfunction

    function int pending();
      return pending_cells.size();
    endfunction

    function in_item_t stored_cell();
      int unsigned addr;
      addr = cur_row * FRAME_MAX_COLUMNS + cur_col;
      return {frame_colors[addr], frame_glyphs[addr]};
    endfunction

    function void note_cell(in_item_t c);
      logic [6*COLOR_W-1:0] rgb;
      int unsigned addr;
      bit changed;
      out_item_t r;
      rgb = {c.fg_red, c.fg_green, c.fg_blue, c.bg_red, c.bg_green, c.bg_blue};
      addr = cur_row * FRAME_MAX_COLUMNS + cur_col;
      changed = (frame_colors[addr] != rgb) || (frame_glyphs[addr] != c.glyph);
      if (changed) begin
        frame_colors[addr] = rgb;
        frame_glyphs[addr] = c.glyph;
        r.cell_column = COL_OUT_W'(cur_col);
        r.cell_row = ROW_OUT_W'(cur_row);
        r.run_start = !prev_changed;
        r.out_fg_red = c.fg_red;
        r.out_fg_green = c.fg_green;
        r.out_fg_blue = c.fg_blue;
        r.out_bg_red = c.bg_red;
        r.out_bg_green = c.bg_green;
        r.out_bg_blue = c.bg_blue;
        r.shown_glyph = (c.glyph == BLANK_GLYPH) ? HALF_BLOCK : c.glyph;
        pending_cells = {pending_cells, r};
      end
      prev_changed = changed;
      if (cur_col + 1 >= size_in_use(cols_reg, FRAME_MAX_COLUMNS)) begin
        cur_col = 0;
        prev_changed = 1'b0;
        if (cur_row + 1 >= size_in_use(rows_reg, FRAME_MAX_ROWS)) cur_row = 0;
        else cur_row = cur_row + 1;
      end else begin
        cur_col = cur_col + 1;
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_cells.size() == 0) begin
        report_mismatch("changed cell reported with no cell expecting it");
        return;
      end
      want = pending_cells.pop_front();
      compare_field("cell_column", 32'(got.cell_column), 32'(want.cell_column));
      compare_field("cell_row", 32'(got.cell_row), 32'(want.cell_row));
      compare_field("run_start", 32'(got.run_start), 32'(want.run_start));
      compare_field("out_fg_red", 32'(got.out_fg_red), 32'(want.out_fg_red));
      compare_field("out_fg_green", 32'(got.out_fg_green), 32'(want.out_fg_green));
      compare_field("out_fg_blue", 32'(got.out_fg_blue), 32'(want.out_fg_blue));
      compare_field("out_bg_red", 32'(got.out_bg_red), 32'(want.out_bg_red));
      compare_field("out_bg_green", 32'(got.out_bg_green), 32'(want.out_bg_green));
      compare_field("out_bg_blue", 32'(got.out_bg_blue), 32'(want.out_bg_blue));
      compare_field("shown_glyph", 32'(got.shown_glyph), 32'(want.shown_glyph));
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_write;
  cfg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  changed_cell_scoreboard sb;
  int send_idle;
  int recv_stall;
  int hold_left;
  int quiet_cycles;

  frame_diff_changed_pixel_runs_unit #(
    .MAX_COLUMNS(FRAME_MAX_COLUMNS),
    .MAX_ROWS(FRAME_MAX_ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) sb.check_result(out_data);
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb_frame_diff_changed_pixel_runs_unit: errors");
    $finish;
  end

  function automatic in_item_t paint(logic [6*COLOR_W-1:0] rgb, logic [GLYPH_W-1:0] g);
    return {rgb, g};
  endfunction

  function automatic logic [GLYPH_W-1:0] pick_glyph();
    int unsigned m;
    m = $urandom_range(99);
    if (m < 30) return BLANK_GLYPH;
    if (m < 38) return HALF_BLOCK;
    if (m < 42) return 21'h10FFFF;
    if (m < 45) return '0;
    if (m < 50) return GLYPH_W'($urandom);
    return GLYPH_W'($urandom_range(21'h10FFFF));
  endfunction

  // Most cells repeat or lightly touch what the frame already holds, so runs form and break.
  function automatic in_item_t pick_cell();
    in_item_t c;
    int unsigned mode;
    c = sb.stored_cell();
    mode = $urandom_range(99);
    if (mode < 40) begin
      return c;
    end else if (mode < 65) begin
      case ($urandom_range(6))
        0: c.fg_red = COLOR_W'($urandom);
        1: c.fg_green = COLOR_W'($urandom);
        2: c.fg_blue = COLOR_W'($urandom);
        3: c.bg_red = COLOR_W'($urandom);
        4: c.bg_green = COLOR_W'($urandom);
        5: c.bg_blue = COLOR_W'($urandom);
        default: c.glyph = pick_glyph();
      endcase
    end else if (mode < 75) begin
      c = paint(BLACK_COLORS, BLANK_GLYPH);
    end else begin
      c = paint({$urandom, 16'($urandom)}, pick_glyph());
    end
    return c;
  endfunction

  task automatic send_cell(input in_item_t c);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_cell(c);
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FRAME_COLUMNS;
    cfg_data <= cols;
    @(posedge clk);
    sb.set_size(CFG_FRAME_COLUMNS, cols);
    cfg_index <= CFG_FRAME_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    sb.set_size(CFG_FRAME_ROWS, rows);
    cfg_write <= 1'b0;
  endtask

  task automatic run_opening_cells();
    send_cell(paint(BLACK_COLORS, BLANK_GLYPH));
    send_cell(paint(BLACK_COLORS, HALF_BLOCK));
    send_cell(paint(48'hFFFFFF_000000, BLANK_GLYPH));
    send_cell(paint('1, 21'h1FFFFF));
    send_cell(paint(BLACK_COLORS, '0));
    send_cell(paint(BLACK_COLORS, BLANK_GLYPH));
    send_cell(paint(48'h0000FF_FF0000, 21'h10FFFF));
    send_cell(paint(48'h000000_000001, BLANK_GLYPH));
    drain_and_settle();
    // The column counter now sits beyond the narrower width and wraps after one cell.
    set_frame(8'd3, 8'd2);
    send_cell(paint(48'h800000_000000, 21'h41));
    send_cell(paint(48'h008000_000000, 21'h42));
    send_cell(paint(BLACK_COLORS, BLANK_GLYPH));
    send_cell(paint(48'h000080_000000, 21'h43));
    send_cell(paint(BLACK_COLORS, HALF_BLOCK));
    send_cell(paint(48'h000000_800000, BLANK_GLYPH));
    send_cell(paint(48'h000000_008000, 21'h44));
    send_cell(paint(48'h000000_000080, 21'h45));
    drain_and_settle();
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows,
                           input int count, input int sidle, input int rstall, input int hold);
    set_frame(cols, rows);
    send_idle = sidle;
    recv_stall = rstall;
    hold_left = hold;
    repeat (count) begin
      sender_gap();
      send_cell(pick_cell());
    end
    drain_and_settle();
  endtask

  initial begin
    sb = new();
    send_idle = 0;
    recv_stall = 0;
    hold_left = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_FRAME_COLUMNS;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_opening_cells();
    run_phase(8'd0, 8'd0, 60, 0, 0, 0);
    run_phase(8'd255, 8'd255, 150, 71, 0, 0);
    run_phase(8'd128, 8'd64, 100, 0, 71, 0);
    run_phase(8'd5, 8'd3, 300, 0, 0, 300);
    run_phase(8'd1, 8'd7, 150, 29, 29, 0);
    run_phase(8'd17, 8'd4, 300, 71, 0, 0);
    run_phase(8'd128, 8'd1, 200, 0, 71, 0);
    run_phase(8'd2, 8'd64, 200, 29, 29, 0);
    run_phase(8'd40, 8'd20, 200, 0, 0, 0);
    run_phase(8'd9, 8'd9, 150, 0, 71, 0);
    if (sb.pending() != 0) sb.report_mismatch("changed cells still expected at the end");
    if (sb.errors == 0) begin
      $display("tb_frame_diff_changed_pixel_runs_unit: clean");
    end else begin
      $display("tb_frame_diff_changed_pixel_runs_unit: errors");
    end
    $finish;
  end

endmodule
